/* hdl/tpds_pkg.sv */
// Shared types and constants for the touch packet decoder.
// Holds the header codes, scaling constants, the raw packet record and parser phases.
// No dependencies.
package tpds_pkg;

    localparam logic [7:0] HDR_MASK     = 8'h81;
    localparam logic [7:0] HDR_PEN_DOWN = 8'h81;
    localparam logic [7:0] HDR_PEN_UP   = 8'h80;

    localparam int RAW_W = 12;

    // x = raw * 799 / 4000, division done as multiply by rounded-up reciprocal
    localparam int          X_PROD_W  = 22;
    localparam logic [9:0]  X_MUL     = 10'd799;
    localparam logic [22:0] X_RECIP   = 23'd4294968;
    localparam int          X_SHIFT   = 34;
    localparam int          X_W       = 10;

    // y = (raw - 120) * 479 / 3900, truncated toward zero
    localparam logic [12:0] Y_OFFSET  = 13'd120;
    localparam int          Y_PROD_W  = 21;
    localparam logic [8:0]  Y_MUL     = 9'd479;
    localparam logic [21:0] Y_RECIP   = 22'd2202548;
    localparam int          Y_SHIFT   = 33;
    localparam int          Y_MAG_W   = 9;
    localparam int          Y_W       = 10;

    typedef struct packed {
        logic             pen;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } raw_pkt_t;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_X_LO = 5'b00010,
        PH_X_HI = 5'b00100,
        PH_Y_LO = 5'b01000,
        PH_Y_HI = 5'b10000
    } phase_t;

endpackage

/* hdl/tpds_parser.sv */
// Front end: hunts for header bytes and assembles four payload bytes.
// Pushes one raw packet per completed frame. Depends on tpds_pkg.
module tpds_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               pkt_valid,
    input  logic               pkt_ready,
    output tpds_pkg::raw_pkt_t pkt
);
    import tpds_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       pen_reg, pen_next;
    logic [11:0] raw_x_reg, raw_x_next;
    logic [6:0] raw_y_low_reg, raw_y_low_next;
    logic [7:0] hdr;
    logic       accept;

    assign in_ready  = (phase_reg != PH_Y_HI) || pkt_ready;
    assign accept    = in_valid && in_ready;
    assign pkt_valid = accept && (phase_reg == PH_Y_HI);
    assign hdr       = rx_byte & HDR_MASK;

    assign pkt.pen   = pen_reg;
    assign pkt.raw_x = raw_x_reg;
    assign pkt.raw_y = {rx_byte[4:0], raw_y_low_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        pen_next       = pen_reg;
        raw_x_next     = raw_x_reg;
        raw_y_low_next = raw_y_low_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_X_LO:
                begin
                    raw_x_next = {5'd0, rx_byte[6:0]};
                    phase_next = PH_X_HI;
                end
                PH_X_HI:
                begin
                    raw_x_next = {rx_byte[4:0], raw_x_reg[6:0]};
                    phase_next = PH_Y_LO;
                end
                PH_Y_LO:
                begin
                    raw_y_low_next = rx_byte[6:0];
                    phase_next     = PH_Y_HI;
                end
                PH_Y_HI:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    if (hdr == HDR_PEN_DOWN)
                    begin
                        pen_next   = 1'b1;
                        phase_next = PH_X_LO;
                    end
                    else if (hdr == HDR_PEN_UP)
                    begin
                        pen_next   = 1'b0;
                        phase_next = PH_X_LO;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pen_reg       <= pen_next;
        raw_x_reg     <= raw_x_next;
        raw_y_low_reg <= raw_y_low_next;
    end

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (phase_reg == PH_Y_HI))
        else $error("parser stalled outside the last payload byte");

    a_push_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after a packet");

endmodule

/* hdl/tpds_queue.sv */
// Short queue of raw packets between the parser and the scaler.
// Register-based circular buffer. Depends on tpds_pkg.
module tpds_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tpds_pkg::raw_pkt_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tpds_pkg::raw_pkt_t pop_data
);
    import tpds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    raw_pkt_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone push");

endmodule

/* hdl/tpds_scaler.sv */
// Back end: scales raw coordinates to screen pixels in three stages.
// Constant multiply, reciprocal multiply, sign and output register. Depends on tpds_pkg.
module tpds_scaler
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tpds_pkg::raw_pkt_t in_pkt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               pen_down,
    output logic [9:0]         screen_x,
    output logic signed [9:0]  screen_y
);
    import tpds_pkg::*;

    localparam int XR_W = X_PROD_W + $bits(X_RECIP);
    localparam int YR_W = Y_PROD_W + $bits(Y_RECIP);

    logic                en1, en2, en3;
    logic                v1_reg, v2_reg, v3_reg;

    logic [12:0]         dy;
    logic                dy_neg;
    logic [12:0]         dy_abs;

    logic                pen1_reg;
    logic [X_PROD_W-1:0] px1_reg;
    logic [Y_PROD_W-1:0] py1_reg;
    logic                neg1_reg;

    logic [XR_W-1:0]     xr;
    logic [YR_W-1:0]     yr;
    logic                pen2_reg;
    logic [X_W-1:0]      qx2_reg;
    logic [Y_MAG_W-1:0]  qy2_reg;
    logic                neg2_reg;

    logic [Y_W-1:0]      y_mag;
    logic                pen3_reg;
    logic [X_W-1:0]      x3_reg;
    logic [Y_W-1:0]      y3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign dy     = {1'b0, in_pkt.raw_y} - Y_OFFSET;
    assign dy_neg = dy[12];
    assign dy_abs = dy_neg ? (Y_OFFSET - {1'b0, in_pkt.raw_y}) : dy;

    assign xr    = XR_W'(px1_reg) * XR_W'(X_RECIP);
    assign yr    = YR_W'(py1_reg) * YR_W'(Y_RECIP);
    assign y_mag = {1'b0, qy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pen1_reg <= in_pkt.pen;
            px1_reg  <= X_PROD_W'(in_pkt.raw_x) * X_PROD_W'(X_MUL);
            py1_reg  <= Y_PROD_W'(dy_abs[11:0]) * Y_PROD_W'(Y_MUL);
            neg1_reg <= dy_neg;
        end
        if (en2)
        begin
            pen2_reg <= pen1_reg;
            qx2_reg  <= xr[X_SHIFT +: X_W];
            qy2_reg  <= yr[Y_SHIFT +: Y_MAG_W];
            neg2_reg <= neg1_reg;
        end
        if (en3)
        begin
            pen3_reg <= pen2_reg;
            x3_reg   <= qx2_reg;
            y3_reg   <= neg2_reg ? (~y_mag + 1'b1) : y_mag;
        end
    end

    assign out_valid = v3_reg;
    assign pen_down  = pen3_reg;
    assign screen_x  = x3_reg;
    assign screen_y  = y3_reg;

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2) |=> v2_reg)
        else $error("scaler lost an item between stages");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (qx2_reg <= X_W'(817)))
        else $error("scaled x out of range");

endmodule

/* hdl/touch_packet_decode_scale.sv */
// Top level of the touch packet decoder with screen scaling.
// Joins parser, packet queue and scaler. Depends on tpds_pkg and all tpds_ modules.
//
// Takes one serial byte per cycle on the in channel unless stalled. Bytes are skipped
// until a header (bits 7 and 0 masked, 0x81 pen down or 0x80 pen up); the next four
// bytes give x low 7, x high 5, y low 7 and y high 5 bits. Each frame yields one
// event: pen_down, screen_x = x*799/4000 and signed screen_y = (y-120)*479/3900
// truncated toward zero. Sustained rate is one byte per cycle while the output is
// not stalled; the scaler is a three-stage pipeline of constant multipliers taking
// one packet per cycle while out_ready allows. A queue of QUEUE_DEPTH packets lets
// the parser keep taking bytes while the output is stalled.
module touch_packet_decode_scale
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pen_down,
    output logic [9:0]        screen_x,
    output logic signed [9:0] screen_y
);
    import tpds_pkg::*;

    logic     pkt_valid;
    logic     pkt_ready;
    raw_pkt_t pkt;
    logic     q_valid;
    logic     q_ready;
    raw_pkt_t q_pkt;

    tpds_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt)
    );

    tpds_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (pkt_valid),
        .push_ready (pkt_ready),
        .push_data  (pkt),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_pkt)
    );

    tpds_scaler u_scaler
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_pkt    (q_pkt),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pen_down  (pen_down),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

endmodule

/* dv/touch_packet_decode_scale_chk.sv */
// Scoreboard for the touch packet decoder: follows byte transfers, predicts each
// pen event with its scaled coordinates and compares it with what leaves the block.
// Depends on tpds_pkg for the header codes.
module touch_packet_decode_scale_chk
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              pen_down,
    input  logic [9:0]        screen_x,
    input  logic signed [9:0] screen_y,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCALE_X_MUL = 799;
    localparam int SCALE_X_DIV = 4000;
    localparam int Y_ZERO      = 120;
    localparam int SCALE_Y_MUL = 479;
    localparam int SCALE_Y_DIV = 3900;

    typedef enum logic [2:0] {WAIT_HDR, GET_X_LO, GET_X_HI, GET_Y_LO, GET_Y_HI} frame_pos_t;

    typedef struct packed {
        logic              pen;
        logic [9:0]        x;
        logic signed [9:0] y;
    } pen_event_t;

    frame_pos_t  frame_pos;
    logic        hdr_pen;
    logic [11:0] coord_x;
    logic [6:0]  coord_y_lo;
    int          dy;
    pen_event_t  ev;
    pen_event_t  want;
    pen_event_t  pending_evts[$];

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos  = WAIT_HDR;
            hdr_pen    = 1'b0;
            coord_x    = '0;
            coord_y_lo = '0;
            fail_count = 0;
            pending_evts.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                case (frame_pos)
                    GET_X_LO:
                    begin
                        coord_x   = {5'd0, rx_byte[6:0]};
                        frame_pos = GET_X_HI;
                    end
                    GET_X_HI:
                    begin
                        coord_x[11:7] = rx_byte[4:0];
                        frame_pos     = GET_Y_LO;
                    end
                    GET_Y_LO:
                    begin
                        coord_y_lo = rx_byte[6:0];
                        frame_pos  = GET_Y_HI;
                    end
                    GET_Y_HI:
                    begin
                        ev.pen = hdr_pen;
                        ev.x   = 10'((int'(coord_x) * SCALE_X_MUL) / SCALE_X_DIV);
                        dy     = int'({rx_byte[4:0], coord_y_lo}) - Y_ZERO;
                        ev.y   = 10'((dy * SCALE_Y_MUL) / SCALE_Y_DIV);
                        pending_evts.push_back(ev);
                        frame_pos = WAIT_HDR;
                    end
                    default:
                    begin
                        if ((rx_byte & tpds_pkg::HDR_MASK) == tpds_pkg::HDR_PEN_DOWN)
                        begin
                            hdr_pen   = 1'b1;
                            frame_pos = GET_X_LO;
                        end
                        else if ((rx_byte & tpds_pkg::HDR_MASK) == tpds_pkg::HDR_PEN_UP)
                        begin
                            hdr_pen   = 1'b0;
                            frame_pos = GET_X_LO;
                        end
                        else
                        begin
                            frame_pos = WAIT_HDR;
                        end
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_evts.size() == 0)
                begin
                    $error("unexpected event: pen_down %0d screen_x %0d screen_y %0d",
                           pen_down, screen_x, screen_y);
                    fail_count++;
                end
                else
                begin
                    want = pending_evts.pop_front();
                    if (pen_down !== want.pen)
                    begin
                        $error("pen_down: expected %0d, actual %0d", want.pen, pen_down);
                        fail_count++;
                    end
                    if (screen_x !== want.x)
                    begin
                        $error("screen_x: expected %0d, actual %0d", want.x, screen_x);
                        fail_count++;
                    end
                    if (screen_y !== want.y)
                    begin
                        $error("screen_y: expected %0d, actual %0d", want.y, screen_y);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = pending_evts.size();
    end

endmodule

/* dv/touch_packet_decode_scale_tb.sv */
// Testbench top for the touch packet decoder: drives serial bytes and output
// back-pressure, and gives the verdict from the scoreboard's failure count.
// Depends on touch_packet_decode_scale and touch_packet_decode_scale_chk.
module touch_packet_decode_scale_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [7:0]        rx_byte   = 8'h00;
    logic              out_ready = 1'b0;
    logic              steady    = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic              pen_down;
    logic [9:0]        screen_x;
    logic signed [9:0] screen_y;
    int                fail_count;
    int                outstanding;
    int                bytes_sent = 0;
    int                pick;
    logic              paused = 1'b0;

    logic [7:0] opening_bytes [23] = '{
        8'h00, 8'h7E, 8'h01,
        8'h81, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'h81, 8'h80, 8'h78, 8'h00,
        8'h80, 8'h7F, 8'h00, 8'h77, 8'h00
    };

    touch_packet_decode_scale u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pen_down  (pen_down),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

    touch_packet_decode_scale_chk u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pen_down    (pen_down),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 38);
    end

    task automatic send_byte(input logic [7:0] b);
        if (!steady)
        begin
            while ($urandom_range(99) < 38)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        while (bytes_sent < 800)
        begin
            steady <= (bytes_sent >= 150 && bytes_sent < 300);
            if (!paused && bytes_sent >= 450)
            begin
                // hold until every outstanding event has drained
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (outstanding != 0);
                @(posedge clk);
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                send_byte(8'($urandom_range(255)) | 8'h80);
                repeat (4) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                send_byte(8'($urandom_range(255)) | 8'h80);
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 95)
            begin
                send_byte(8'($urandom_range(127)));
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** touch_packet_decode_scale: PASSED **");
        else
            $display("** touch_packet_decode_scale: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** touch_packet_decode_scale: FAILED **");
        $finish;
    end

endmodule
